>>> sv/ders_pkg.sv
package ders_pkg;

  // Field widths
  localparam int LEN_W   = 7;
  localparam int STEP_W  = 6;
  localparam int PULSE_W = 7;
  localparam int ROT_W   = 8;
  localparam int IDX_W   = 3;
  localparam int DATA_W  = 8;

  // Longest pattern; larger lengths saturate to this
  localparam logic [LEN_W-1:0] MAX_LENGTH = LEN_W'(64);

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_PATTERN_LENGTH  = 3'd0,
    REG_FIRST_PULSES    = 3'd1,
    REG_SECOND_PULSES   = 3'd2,
    REG_FIRST_ROTATION  = 3'd3,
    REG_SECOND_ROTATION = 3'd4,
    REG_TRACK_ROTATION  = 3'd5,
    REG_COMBINE_MODE    = 3'd6
  } cfg_reg_t;

  // Combine modes
  typedef enum logic [1:0] {
    MODE_OR     = 2'd0,
    MODE_XOR    = 2'd1,
    MODE_AND    = 2'd2,
    MODE_ANDNOT = 2'd3
  } mode_t;

  // Per-item control carried alongside the pipeline data
  typedef struct packed {
    logic               zero;   // forced no-pulse (zero length or step past end)
    mode_t              mode;
    logic [PULSE_W-1:0] p1;     // saturated pulse counts
    logic [PULSE_W-1:0] p2;
  } side_t;

endpackage

>>> sv/ders_mod_pipe.sv
// Pipelined remainder of two values by a shared divisor (restoring, SPS bits per stage)
module ders_mod_pipe
  import ders_pkg::*;
#(
  parameter int DW  = 15,
  parameter int SPS = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [LEN_W-1:0]  in_len,
  input  logic [DW-1:0]     in_a,
  input  logic [DW-1:0]     in_b,
  input  side_t             in_side,
  output logic              out_valid,
  output logic [LEN_W-1:0]  out_len,
  output logic [STEP_W-1:0] out_a,
  output logic [STEP_W-1:0] out_b,
  output side_t             out_side
);

  localparam int NS = (DW + SPS - 1) / SPS;

  // SPS compare-subtract steps, starting at divisor shift k0
  function automatic logic [DW-1:0] stage_fn(input logic [DW-1:0] r,
                                             input logic [LEN_W-1:0] d,
                                             input int k0);
    logic [DW-1:0]       v;
    logic [DW+LEN_W-1:0] dk;
    v = r;
    for (int j = 0; j < SPS; j++) begin
      if (k0 - j >= 0) begin
        dk = {{DW{1'b0}}, d} << (k0 - j);
        if ({{LEN_W{1'b0}}, v} >= dk) v = v - dk[DW-1:0];
      end
    end
    return v;
  endfunction

  logic [NS-1:0]    vld_q;
  logic [LEN_W-1:0] len_q  [NS];
  logic [DW-1:0]    a_q    [NS];
  logic [DW-1:0]    b_q    [NS];
  side_t            side_q [NS];

  logic [DW-1:0]    a_next [NS];
  logic [DW-1:0]    b_next [NS];

  // Stage logic: each stage reduces the remainder below the next divisor shift
  for (genvar g = 0; g < NS; g++) begin : g_stage
    localparam int K0 = DW - 1 - g * SPS;
    if (g == 0) begin : g_first
      assign a_next[g] = stage_fn(in_a, in_len, K0);
      assign b_next[g] = stage_fn(in_b, in_len, K0);
    end else begin : g_rest
      assign a_next[g] = stage_fn(a_q[g-1], len_q[g-1], K0);
      assign b_next[g] = stage_fn(b_q[g-1], len_q[g-1], K0);
    end
  end

  // Valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else begin
      vld_q[0] <= in_valid;
      for (int g = 1; g < NS; g++) vld_q[g] <= vld_q[g-1];
    end
  end

  // Payload chain
  always_ff @(posedge clk) begin
    len_q[0]  <= in_len;
    side_q[0] <= in_side;
    for (int g = 1; g < NS; g++) begin
      len_q[g]  <= len_q[g-1];
      side_q[g] <= side_q[g-1];
    end
    for (int g = 0; g < NS; g++) begin
      a_q[g] <= a_next[g];
      b_q[g] <= b_next[g];
    end
  end

  assign out_valid = vld_q[NS-1];
  assign out_len   = len_q[NS-1];
  assign out_a     = a_q[NS-1][STEP_W-1:0];
  assign out_b     = b_q[NS-1][STEP_W-1:0];
  assign out_side  = side_q[NS-1];

endmodule

>>> sv/dual_euclidean_rhythm_step.sv
// Throughput: one query per cycle; busy is low except during reset.
// Nine register stages: input capture, rotation remainder (3), pulse product,
// product remainder (3), combine/output; each rotation remainder stage does
// 5 subtract steps and each product remainder stage does 4.
// Reset (rst, synchronous) clears the pipeline and loads register defaults.
// The receiver cannot stall; every result is presented for exactly one cycle.
module dual_euclidean_rhythm_step
  import ders_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // query channel
  input  logic              start,
  output logic              busy,
  input  logic [STEP_W-1:0] step,
  output logic              done,
  output logic              pulse,
  // configuration write channel
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [DATA_W-1:0] cfg_data
);

  localparam int ROT_DW  = 15;   // offset rotation value width
  localparam int PROD_W  = 12;   // step * pulses, at most 63 * 64
  localparam int SUM_W   = 16;

  // ---------------- configuration registers ----------------
  logic [LEN_W-1:0]   pattern_length;
  logic [PULSE_W-1:0] first_pulses;
  logic [PULSE_W-1:0] second_pulses;
  logic [ROT_W-1:0]   first_rotation;
  logic [ROT_W-1:0]   second_rotation;
  logic [ROT_W-1:0]   track_rotation;
  mode_t              combine_mode;

  assign cfg_ready = 1'b1;
  assign busy      = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length  <= LEN_W'(16);
      first_pulses    <= PULSE_W'(4);
      second_pulses   <= PULSE_W'(3);
      first_rotation  <= '0;
      second_rotation <= '0;
      track_rotation  <= '0;
      combine_mode    <= MODE_OR;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PATTERN_LENGTH:  pattern_length  <= cfg_data[LEN_W-1:0];
        REG_FIRST_PULSES:    first_pulses    <= cfg_data[PULSE_W-1:0];
        REG_SECOND_PULSES:   second_pulses   <= cfg_data[PULSE_W-1:0];
        REG_FIRST_ROTATION:  first_rotation  <= cfg_data[ROT_W-1:0];
        REG_SECOND_ROTATION: second_rotation <= cfg_data[ROT_W-1:0];
        REG_TRACK_ROTATION:  track_rotation  <= cfg_data[ROT_W-1:0];
        REG_COMBINE_MODE:    combine_mode    <= mode_t'(cfg_data[1:0]);
        default: ;  // unused index, write ignored
      endcase
    end
  end

  // ---------------- stage A: saturation and rotation offset ----------------
  logic [LEN_W-1:0]   len_eff;
  logic [PULSE_W-1:0] p1_eff, p2_eff;
  logic [SUM_W-1:0]   x1_sum, x2_sum, base_sum;
  side_t              side_d;

  always_comb begin
    len_eff = (pattern_length > MAX_LENGTH) ? MAX_LENGTH : pattern_length;
    p1_eff  = (first_pulses  > len_eff) ? len_eff : first_pulses;
    p2_eff  = (second_pulses > len_eff) ? len_eff : second_pulses;
    // step - track + len*256 keeps the value non-negative for any rotation
    base_sum = {{(SUM_W-STEP_W){1'b0}}, step}
             - {{(SUM_W-ROT_W){track_rotation[ROT_W-1]}}, track_rotation}
             + {1'b0, len_eff, 8'b0};
    x1_sum = base_sum - {{(SUM_W-ROT_W){first_rotation[ROT_W-1]}}, first_rotation};
    x2_sum = base_sum - {{(SUM_W-ROT_W){second_rotation[ROT_W-1]}}, second_rotation};
    side_d.zero = (len_eff == '0) || ({1'b0, step} >= len_eff);
    side_d.mode = combine_mode;
    side_d.p1   = p1_eff;
    side_d.p2   = p2_eff;
  end

  logic              a_vld;
  logic [LEN_W-1:0]  a_len;
  logic [ROT_DW-1:0] a_x1, a_x2;
  side_t             a_side;

  always_ff @(posedge clk) begin
    if (rst) a_vld <= 1'b0;
    else     a_vld <= start && !busy;
  end

  always_ff @(posedge clk) begin
    a_len  <= len_eff;
    a_x1   <= x1_sum[ROT_DW-1:0];
    a_x2   <= x2_sum[ROT_DW-1:0];
    a_side <= side_d;
  end

  // ---------------- rotated step modulo length ----------------
  logic              r_vld;
  logic [LEN_W-1:0]  r_len;
  logic [STEP_W-1:0] r_s1, r_s2;
  side_t             r_side;

  ders_mod_pipe #(.DW(ROT_DW), .SPS(5)) u_rot_mod (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (a_vld),
    .in_len    (a_len),
    .in_a      (a_x1),
    .in_b      (a_x2),
    .in_side   (a_side),
    .out_valid (r_vld),
    .out_len   (r_len),
    .out_a     (r_s1),
    .out_b     (r_s2),
    .out_side  (r_side)
  );

  // ---------------- product stage: step * pulses ----------------
  logic [STEP_W+PULSE_W-1:0] prod1_full, prod2_full;
  logic                      m_vld;
  logic [LEN_W-1:0]          m_len;
  logic [PROD_W-1:0]         m_p1, m_p2;
  side_t                     m_side;

  assign prod1_full = {{PULSE_W{1'b0}}, r_s1} * {{STEP_W{1'b0}}, r_side.p1};
  assign prod2_full = {{PULSE_W{1'b0}}, r_s2} * {{STEP_W{1'b0}}, r_side.p2};

  always_ff @(posedge clk) begin
    if (rst) m_vld <= 1'b0;
    else     m_vld <= r_vld;
  end

  always_ff @(posedge clk) begin
    m_len  <= r_len;
    m_p1   <= prod1_full[PROD_W-1:0];
    m_p2   <= prod2_full[PROD_W-1:0];
    m_side <= r_side;
  end

  // ---------------- product modulo length ----------------
  logic              q_vld;
  logic [LEN_W-1:0]  q_len;
  logic [STEP_W-1:0] q_m1, q_m2;
  side_t             q_side;

  ders_mod_pipe #(.DW(PROD_W), .SPS(4)) u_prod_mod (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (m_vld),
    .in_len    (m_len),
    .in_a      (m_p1),
    .in_b      (m_p2),
    .in_side   (m_side),
    .out_valid (q_vld),
    .out_len   (q_len),
    .out_a     (q_m1),
    .out_b     (q_m2),
    .out_side  (q_side)
  );

  // ---------------- fire test and combine ----------------
  // A generator fires when a multiple of len lies in [s*p, s*p+p):
  // remainder m is zero, or m + p exceeds len.
  logic g1, g2, comb;

  always_comb begin
    g1 = (q_side.p1 != '0) &&
         ((q_m1 == '0) ||
          ({2'b0, q_m1} + {1'b0, q_side.p1} > {1'b0, q_len}));
    g2 = (q_side.p2 != '0) &&
         ((q_m2 == '0) ||
          ({2'b0, q_m2} + {1'b0, q_side.p2} > {1'b0, q_len}));
    case (q_side.mode)
      MODE_OR:     comb = g1 | g2;
      MODE_XOR:    comb = g1 ^ g2;
      MODE_AND:    comb = g1 & g2;
      MODE_ANDNOT: comb = g1 & ~g2;
      default:     comb = 1'b0;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= q_vld;
  end

  always_ff @(posedge clk) begin
    pulse <= comb && !q_side.zero;
  end

endmodule

>>> test/rhythm_checker.sv
`timescale 1ns / 1ps

// Watches the query, result and register-write channels of the rhythm
// block, predicts every pulse and checks the results in order.
module rhythm_checker
  import ders_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic [STEP_W-1:0] step,
  input  logic              done,
  input  logic              pulse,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [DATA_W-1:0] cfg_data,
  output int                fails,
  output int                pending,
  output int                checked,
  output int                ones
);

  typedef struct {
    logic [STEP_W-1:0] step;
    logic              pulse;
  } pulse_due_t;

  pulse_due_t pulse_due[$];

  // shadow copy of the register file
  logic [LEN_W-1:0]          len_reg;
  logic [PULSE_W-1:0]        p1_reg;
  logic [PULSE_W-1:0]        p2_reg;
  logic signed [ROT_W-1:0]   rot1_reg;
  logic signed [ROT_W-1:0]   rot2_reg;
  logic signed [ROT_W-1:0]   trk_reg;
  mode_t                     mode_reg;

  // (s - amt) mod len, always in 0..len-1
  function automatic int wrap_sub(int s, int amt, int len);
    int x;
    x = (s - amt) % len;
    if (x < 0) x += len;
    return x;
  endfunction

  // one Euclidean generator: pulse k sits at floor(k*len/p)
  function automatic bit euclid_fires(int s, int p, int len);
    int k;
    if (p > len) p = len;
    if (p == 0 || s >= len) return 1'b0;
    k = (s * p + len - 1) / len;
    if (k >= p) return 1'b0;
    return (k * len / p) == s;
  endfunction

  function automatic logic rhythm_hit(logic [STEP_W-1:0] q);
    int len;
    int s;
    bit g1;
    bit g2;
    len = (len_reg > MAX_LENGTH) ? int'(MAX_LENGTH) : int'(len_reg);
    if (len == 0 || int'(q) >= len) return 1'b0;
    s  = wrap_sub(int'(q), int'(trk_reg), len);
    g1 = euclid_fires(wrap_sub(s, int'(rot1_reg), len), int'(p1_reg), len);
    g2 = euclid_fires(wrap_sub(s, int'(rot2_reg), len), int'(p2_reg), len);
    case (mode_reg)
      MODE_XOR:    return g1 ^ g2;
      MODE_AND:    return g1 & g2;
      MODE_ANDNOT: return g1 & ~g2;
      default:     return g1 | g2;
    endcase
  endfunction

  // one line per mismatch, every one counted
  task automatic report(string what);
    $display("[%0t] mismatch: %s", $time, what);
    fails++;
  endtask

  always @(posedge clk) begin : watch
    pulse_due_t d;
    if (rst) begin
      len_reg  <= LEN_W'(16);
      p1_reg   <= PULSE_W'(4);
      p2_reg   <= PULSE_W'(3);
      rot1_reg <= '0;
      rot2_reg <= '0;
      trk_reg  <= '0;
      mode_reg <= MODE_OR;
      pulse_due.delete();
      if (done) report("result strobed during reset");
    end else begin
      // result transfer
      if (done) begin
        if (pulse_due.size() == 0) begin
          report($sformatf("unexpected result pulse=%b", pulse));
        end else begin
          d = pulse_due.pop_front();
          checked++;
          if (pulse === 1'b1) ones++;
          if (pulse !== d.pulse)
            report($sformatf("step %0d: pulse %b, expected %b", d.step, pulse, d.pulse));
        end
      end
      // query transfer: predict with the settings in force now
      if (start && !busy) begin
        d.step  = step;
        d.pulse = rhythm_hit(step);
        pulse_due.push_back(d);
      end
      // register write transfer
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PATTERN_LENGTH:  len_reg  <= cfg_data[LEN_W-1:0];
          REG_FIRST_PULSES:    p1_reg   <= cfg_data[PULSE_W-1:0];
          REG_SECOND_PULSES:   p2_reg   <= cfg_data[PULSE_W-1:0];
          REG_FIRST_ROTATION:  rot1_reg <= cfg_data;
          REG_SECOND_ROTATION: rot2_reg <= cfg_data;
          REG_TRACK_ROTATION:  trk_reg  <= cfg_data;
          REG_COMBINE_MODE:    mode_reg <= mode_t'(cfg_data[1:0]);
          default: ;  // unmapped index: ignored
        endcase
      end
    end
    pending = pulse_due.size();
  end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
  import ders_pkg::*;

  localparam logic [IDX_W-1:0] REG_SPARE = IDX_W'(7);  // unmapped index
  // slowest run: ~1450 queries, each after the longest sender gap, plus drains
  localparam int LIMIT  = 400000;
  localparam int DRAIN  = 12;
  localparam int PHASES = 14;
  localparam int PER_PHASE = 100;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic [STEP_W-1:0] step = '0;
  logic              cfg_valid = 1'b0;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;
  logic              busy;
  logic              done;
  logic              pulse;
  logic              cfg_ready;

  int fails;
  int pending;
  int checked;
  int ones;
  int cycles = 0;
  int settings = 0;
  int cur_len = 16;  // effective length, used only to aim the steps and pulse counts
  bit gaps_on = 1'b1;

  always #6 clk = ~clk;

  dual_euclidean_rhythm_step dut (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy), .step(step),
    .done(done), .pulse(pulse),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  rhythm_checker chk (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy), .step(step),
    .done(done), .pulse(pulse),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fails(fails), .pending(pending), .checked(checked), .ones(ones)
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("dual_euclidean_rhythm_step regression: fail");
      $finish;
    end
  end

  // one query transfer; start is left high for a following item
  task automatic query(logic [STEP_W-1:0] v);
    start <= 1'b1;
    step  <= v;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  // sender idle time: mostly none or short, now and then long
  task automatic sender_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 45) n = 0;
    else if (r < 85) n = $urandom_range(1, 3);
    else if (r < 96) n = $urandom_range(4, 10);
    else n = $urandom_range(20, 60);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // stop sending and wait until every pulse has come back
  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // one register write transfer; valid stays high for a following write
  task automatic cfg_write(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    if (idx == REG_PATTERN_LENGTH)
      cur_len = (int'(data[LEN_W-1:0]) > 64) ? 64 : int'(data[LEN_W-1:0]);
  endtask

  task automatic cfg_end();
    cfg_valid <= 1'b0;
    settings++;
  endtask

  function automatic int pick_pulses();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return cur_len;
    if (r == 2) return $urandom_range(cur_len, 255);  // above length, top bit noise
    return $urandom_range(0, cur_len);
  endfunction

  // random register setting; the first phases pin the extremes
  task automatic random_setup(int ph);
    int len_data;
    int r;
    logic [1:0] m;
    r = $urandom_range(0, 9);
    if (ph == 0) len_data = 64;
    else if (ph == 1) len_data = 1;
    else if (ph == 2) len_data = 0;
    else if (r == 0) len_data = $urandom_range(65, 255);
    else if (r == 1) len_data = 64;
    else len_data = $urandom_range(2, 63);
    m = (ph < 4) ? 2'(ph) : 2'($urandom_range(0, 3));
    cfg_write(REG_PATTERN_LENGTH, DATA_W'(len_data));
    if (ph == 0) begin
      cfg_write(REG_FIRST_PULSES, 8'd64);
      cfg_write(REG_SECOND_PULSES, 8'd127);
      cfg_write(REG_FIRST_ROTATION, 8'h80);
      cfg_write(REG_SECOND_ROTATION, 8'h7F);
      cfg_write(REG_TRACK_ROTATION, 8'h80);
    end else begin
      cfg_write(REG_FIRST_PULSES, DATA_W'(pick_pulses()));
      cfg_write(REG_SECOND_PULSES, DATA_W'(pick_pulses()));
      cfg_write(REG_FIRST_ROTATION, DATA_W'($urandom_range(0, 255)));
      cfg_write(REG_SECOND_ROTATION, DATA_W'($urandom_range(0, 255)));
      cfg_write(REG_TRACK_ROTATION, DATA_W'($urandom_range(0, 255)));
    end
    cfg_write(REG_COMBINE_MODE, {6'($urandom_range(0, 63)), m});
    if ($urandom_range(0, 2) == 0) cfg_write(REG_SPARE, DATA_W'($urandom_range(0, 255)));
    cfg_end();
  endtask

  // steps mostly inside the pattern, some anywhere
  function automatic logic [STEP_W-1:0] pick_step();
    if (cur_len == 0 || $urandom_range(0, 99) < 15) return STEP_W'($urandom_range(0, 63));
    return STEP_W'($urandom_range(0, cur_len - 1));
  endfunction

  initial begin : stimulus
    logic [STEP_W-1:0] probe[$];
    probe = '{6'd1, 6'd6, 6'd11};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: pulses on the grid, the last step and past the end
    query(6'd0);
    query(6'd4);
    query(6'd8);
    query(6'd12);
    query(6'd15);
    query(6'd16);
    query(6'd63);
    drain();

    // zero length gives no pulse anywhere
    cfg_write(REG_PATTERN_LENGTH, 8'd0);
    cfg_end();
    query(6'd0);
    query(6'd63);
    drain();

    // oversized length and pulse count saturate; zero pulses never fire
    cfg_write(REG_PATTERN_LENGTH, 8'hFF);
    cfg_write(REG_FIRST_PULSES, 8'h7F);
    cfg_write(REG_SECOND_PULSES, 8'd0);
    cfg_write(REG_FIRST_ROTATION, 8'h80);
    cfg_write(REG_SECOND_ROTATION, 8'h7F);
    cfg_write(REG_TRACK_ROTATION, 8'h01);
    cfg_write(REG_SPARE, 8'hA5);
    cfg_end();
    query(6'd0);
    query(6'd63);
    query(6'd31);
    drain();

    // remaining combine modes on a short odd pattern
    cfg_write(REG_PATTERN_LENGTH, 8'd12);
    cfg_write(REG_FIRST_PULSES, 8'd5);
    cfg_write(REG_SECOND_PULSES, 8'd7);
    cfg_write(REG_FIRST_ROTATION, 8'hFD);
    cfg_write(REG_SECOND_ROTATION, 8'd2);
    cfg_write(REG_TRACK_ROTATION, 8'hF4);
    cfg_write(REG_COMBINE_MODE, {6'd0, MODE_XOR});
    cfg_end();
    foreach (probe[i]) query(probe[i]);
    drain();
    cfg_write(REG_COMBINE_MODE, {6'd0, MODE_AND});
    cfg_end();
    foreach (probe[i]) query(probe[i]);
    drain();
    cfg_write(REG_COMBINE_MODE, {6'd0, MODE_ANDNOT});
    cfg_end();
    foreach (probe[i]) query(probe[i]);

    // random phases, each under a fresh register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      random_setup(ph);
      gaps_on = (ph % 5 != 3);  // some phases run back to back
      for (int k = 0; k < PER_PHASE; k++) begin
        query(pick_step());
        if ($urandom_range(0, 149) == 0) drain();
        else sender_gap();
      end
    end

    drain();
    repeat (DRAIN) @(posedge clk);

    $display("covered %0d queries (%0d pulses) over %0d register settings,", checked, ones,
             settings);
    $display("all four combine modes, zero, saturated and oversized lengths and pulse counts");
    if (fails == 0) begin
      $display("dual_euclidean_rhythm_step regression: pass");
    end else begin
      $display("%0d mismatches", fails);
      $display("dual_euclidean_rhythm_step regression: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/ders_pkg.sv
sv/ders_mod_pipe.sv
sv/dual_euclidean_rhythm_step.sv
test/rhythm_checker.sv
test/tb.sv
